/* src/btkh_pkg.sv */
// ----------------------------------------------------------------------------
// btkh_pkg: shared types and constants of the bounded top-k heap
// Word layouts, field codes, register indexes and derived widths.
// ----------------------------------------------------------------------------
package btkh_pkg;

  // largest number of values the heap can keep
  localparam int MAX_KEEP = 32;

  // heap position and fill widths
  localparam int IDX_W  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int FILL_W = $clog2(MAX_KEEP + 1);
  // child index width: 2*pos+2 must fit
  localparam int CH_W   = IDX_W + 2;

  localparam int VAL_W  = 32;
  localparam int KIND_W = 2;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam int KC_W       = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_MAX = 1'd1;

  // command kinds
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [VAL_W-1:0] value;
    logic                    is_null;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] kept_value;
    logic                    last_one;
    logic                    none_kept;
  } out_word_t;

endpackage

/* src/bounded_top_k_min_max_heap_top.sv */
// ----------------------------------------------------------------------------
// bounded_top_k_min_max_heap_top: keeps the N best signed values seen
// Binary heap with the worst kept value at the root; sorted read out.
// ----------------------------------------------------------------------------
// Usage:
//   A command word is taken at a clock edge with start high and busy low.
//   Kinds: add a value (ignored when null), read out, clear.
//   Results appear on res_word_o for one cycle each, marked by res_valid_o;
//   the receiver takes every result and cannot stall the block.
//   Command steps:
//     clear empties the heap; null add and unused kind change nothing.
//     add while not full: the value climbs from the next free slot.
//     add when full: the root is tested first; a replacing value then
//     sifts down level by level and settles.
//     read of n values: n inserts into a scratch heap, then n extracts,
//     all but the last followed by a resift; one result per extract.
//     An empty read gives one result flagged none_kept the next cycle.
//   All of this goes through one storage array (one write port, two
//   registered read ports) and one shared compare unit, one level a step.
//   Reset empties the heap, keep_count = 1, select_max = 0.
//   The user must write configuration through cfg_we_i only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module bounded_top_k_min_max_heap_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  btkh_pkg::in_word_t                  in_word_i,
  output logic                                res_valid_o,
  output btkh_pkg::out_word_t                 res_word_o,
  input  logic                                cfg_we_i,
  input  logic [btkh_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [btkh_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int IDX_W  = btkh_pkg::IDX_W;
  localparam int FILL_W = btkh_pkg::FILL_W;
  localparam int CH_W   = btkh_pkg::CH_W;
  localparam int VAL_W  = btkh_pkg::VAL_W;
  localparam int ADDR_W = IDX_W + 1;
  localparam int DEPTH  = 2 * btkh_pkg::MAX_KEEP;

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ADD_CHK = 4'd1;
  localparam logic [3:0] S_UP_RD   = 4'd2;
  localparam logic [3:0] S_UP_CMP  = 4'd3;
  localparam logic [3:0] S_DN_RD   = 4'd4;
  localparam logic [3:0] S_DN_CMPL = 4'd5;
  localparam logic [3:0] S_DN_CMPR = 4'd6;
  localparam logic [3:0] S_CP_RD   = 4'd7;
  localparam logic [3:0] S_CP_LD   = 4'd8;
  localparam logic [3:0] S_EX_RD   = 4'd9;
  localparam logic [3:0] S_EX_OUT  = 4'd10;

  // what a finished sift returns to
  localparam logic [1:0] CTX_ADD  = 2'd0;
  localparam logic [1:0] CTX_COPY = 2'd1;
  localparam logic [1:0] CTX_EXTR = 2'd2;

  // region of the storage array: kept heap or scratch sort heap
  localparam logic REG_HEAP    = 1'b0;
  localparam logic REG_SCRATCH = 1'b1;

  logic [3:0]                 state_q, state_d;
  logic [1:0]                 ctx_q, ctx_d;
  logic                       region_q, region_d;
  logic signed [VAL_W-1:0]    cur_q, cur_d;
  logic [IDX_W-1:0]           pos_q, pos_d;
  logic signed [VAL_W-1:0]    best_val_q, best_val_d;
  logic [IDX_W-1:0]           best_idx_q, best_idx_d;
  logic [FILL_W-1:0]          fill_q, fill_d;
  logic [FILL_W-1:0]          sfill_q, sfill_d;
  logic [FILL_W-1:0]          cnt_q, cnt_d;
  logic [btkh_pkg::KC_W-1:0]  keep_count_q;
  logic                       select_max_q;
  logic                       res_valid_q, res_valid_d;
  btkh_pkg::out_word_t        res_word_q, res_word_d;

  // storage array and its ports
  logic signed [VAL_W-1:0]    mem_q [DEPTH];
  logic signed [VAL_W-1:0]    rd_a_q, rd_b_q;
  logic                       ren_a, ren_b, we;
  logic [ADDR_W-1:0]          raddr_a, raddr_b, waddr;
  logic signed [VAL_W-1:0]    wdata;

  // compare unit hookup
  logic signed [VAL_W-1:0]    cmp_a, cmp_b;
  logic                       cmp_best_first;
  logic                       cmp_before;

  // derived values
  logic [FILL_W-1:0]          limit;
  logic [FILL_W-1:0]          heap_n;
  logic [IDX_W-1:0]           parent;
  logic [CH_W-1:0]            child_l, child_r, n_ext;
  logic [FILL_W-1:0]          cnt_inc;
  logic [FILL_W-1:0]          sfill_dec;
  logic                       accept;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  // clamp keep_count into 1..MAX_KEEP
  always_comb begin
    if (keep_count_q == '0) begin
      limit = FILL_W'(1);
    end else if (int'(keep_count_q) > btkh_pkg::MAX_KEEP) begin
      limit = FILL_W'(btkh_pkg::MAX_KEEP);
    end else begin
      limit = FILL_W'(keep_count_q);
    end
  end

  assign heap_n    = (region_q == REG_SCRATCH) ? sfill_q : fill_q;
  assign parent    = (pos_q - IDX_W'(1)) >> 1;
  assign child_l   = (CH_W'(pos_q) << 1) + CH_W'(1);
  assign child_r   = child_l + CH_W'(1);
  assign n_ext     = CH_W'(heap_n);
  assign cnt_inc   = cnt_q + FILL_W'(1);
  assign sfill_dec = sfill_q - FILL_W'(1);

  // compare operand selection
  always_comb begin
    cmp_a          = cur_q;
    cmp_b          = rd_a_q;
    cmp_best_first = region_q;
    unique case (state_q)
      S_ADD_CHK: begin
        cmp_best_first = 1'b1;
      end
      S_DN_CMPL: begin
        cmp_a = rd_a_q;
        cmp_b = cur_q;
      end
      S_DN_CMPR: begin
        cmp_a = rd_b_q;
        cmp_b = best_val_q;
      end
      default: begin
      end
    endcase
  end

  btkh_cmp u_cmp (
    .a_i          (cmp_a),
    .b_i          (cmp_b),
    .select_max_i (select_max_q),
    .best_first_i (cmp_best_first),
    .before_o     (cmp_before)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    ctx_d       = ctx_q;
    region_d    = region_q;
    cur_d       = cur_q;
    pos_d       = pos_q;
    best_val_d  = best_val_q;
    best_idx_d  = best_idx_q;
    fill_d      = fill_q;
    sfill_d     = sfill_q;
    cnt_d       = cnt_q;
    res_valid_d = 1'b0;
    res_word_d  = res_word_q;
    ren_a       = 1'b0;
    ren_b       = 1'b0;
    raddr_a     = '0;
    raddr_b     = '0;
    we          = 1'b0;
    waddr       = {region_q, pos_q};
    wdata       = cur_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_word_i.kind)
            btkh_pkg::KIND_ADD: begin
              if (!in_word_i.is_null) begin
                cur_d    = in_word_i.value;
                region_d = REG_HEAP;
                ctx_d    = CTX_ADD;
                if (fill_q < limit) begin
                  // room left: climb from the next free slot
                  pos_d   = fill_q[IDX_W-1:0];
                  fill_d  = fill_q + FILL_W'(1);
                  state_d = S_UP_RD;
                end else begin
                  // full: test against the root first
                  ren_a   = 1'b1;
                  raddr_a = {REG_HEAP, IDX_W'(0)};
                  state_d = S_ADD_CHK;
                end
              end
            end
            btkh_pkg::KIND_READ: begin
              if (fill_q == '0) begin
                res_valid_d           = 1'b1;
                res_word_d.kept_value = '0;
                res_word_d.last_one   = 1'b1;
                res_word_d.none_kept  = 1'b1;
              end else begin
                cnt_d   = '0;
                sfill_d = fill_q;
                ctx_d   = CTX_COPY;
                state_d = S_CP_RD;
              end
            end
            btkh_pkg::KIND_CLEAR: begin
              fill_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_ADD_CHK: begin
        // replace root only when strictly better
        if (cmp_before) begin
          pos_d   = '0;
          state_d = S_DN_RD;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_UP_RD: begin
        if (pos_q == '0) begin
          we = 1'b1;
          state_d = S_IDLE;
        end else begin
          ren_a   = 1'b1;
          raddr_a = {region_q, parent};
          state_d = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        we = 1'b1;
        if (cmp_before) begin
          // parent moves down into the hole
          wdata   = rd_a_q;
          pos_d   = parent;
          state_d = S_UP_RD;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_DN_RD: begin
        if (child_l >= n_ext) begin
          we = 1'b1;
          state_d = S_IDLE;
        end else begin
          ren_a   = 1'b1;
          raddr_a = {region_q, child_l[IDX_W-1:0]};
          ren_b   = 1'b1;
          raddr_b = {region_q, child_r[IDX_W-1:0]};
          state_d = S_DN_CMPL;
        end
      end

      S_DN_CMPL: begin
        if (cmp_before) begin
          best_val_d = rd_a_q;
          best_idx_d = child_l[IDX_W-1:0];
        end else begin
          best_val_d = cur_q;
          best_idx_d = pos_q;
        end
        state_d = S_DN_CMPR;
      end

      S_DN_CMPR: begin
        logic signed [VAL_W-1:0] w_val;
        logic [IDX_W-1:0]        w_idx;
        w_val = best_val_q;
        w_idx = best_idx_q;
        if ((child_r < n_ext) && cmp_before) begin
          w_val = rd_b_q;
          w_idx = child_r[IDX_W-1:0];
        end
        we = 1'b1;
        if (w_idx == pos_q) begin
          state_d = S_IDLE;
        end else begin
          // child moves up into the hole
          wdata   = w_val;
          pos_d   = w_idx;
          state_d = S_DN_RD;
        end
      end

      S_CP_RD: begin
        ren_a   = 1'b1;
        raddr_a = {REG_HEAP, cnt_q[IDX_W-1:0]};
        state_d = S_CP_LD;
      end

      S_CP_LD: begin
        // insert the copied word into the scratch heap, best at root
        cur_d    = rd_a_q;
        pos_d    = cnt_q[IDX_W-1:0];
        region_d = REG_SCRATCH;
        state_d  = S_UP_RD;
      end

      S_EX_RD: begin
        ren_a   = 1'b1;
        raddr_a = {REG_SCRATCH, IDX_W'(0)};
        ren_b   = 1'b1;
        raddr_b = {REG_SCRATCH, sfill_dec[IDX_W-1:0]};
        state_d = S_EX_OUT;
      end

      S_EX_OUT: begin
        res_valid_d           = 1'b1;
        res_word_d.kept_value = rd_a_q;
        res_word_d.last_one   = (sfill_q == FILL_W'(1));
        res_word_d.none_kept  = 1'b0;
        sfill_d               = sfill_dec;
        if (sfill_q == FILL_W'(1)) begin
          state_d = S_IDLE;
        end else begin
          // last word refills the root and sinks
          cur_d   = rd_b_q;
          pos_d   = '0;
          ctx_d   = CTX_EXTR;
          state_d = S_DN_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // a sift that ends in IDLE returns to its caller
    if (busy && (state_d == S_IDLE) && (state_q != S_ADD_CHK) &&
        (state_q != S_EX_OUT)) begin
      case (ctx_q)
        CTX_COPY: begin
          cnt_d    = cnt_inc;
          region_d = REG_HEAP;
          if (cnt_inc == fill_q) begin
            region_d = REG_SCRATCH;
            state_d  = S_EX_RD;
          end else begin
            state_d = S_CP_RD;
          end
        end
        CTX_EXTR: begin
          state_d = S_EX_RD;
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ctx_q        <= CTX_ADD;
      region_q     <= REG_HEAP;
      fill_q       <= '0;
      sfill_q      <= '0;
      cnt_q        <= '0;
      res_valid_q  <= 1'b0;
      keep_count_q <= btkh_pkg::KC_W'(1);
      select_max_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctx_q       <= ctx_d;
      region_q    <= region_d;
      fill_q      <= fill_d;
      sfill_q     <= sfill_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          btkh_pkg::CFG_KEEP_COUNT: keep_count_q <= cfg_data_i[btkh_pkg::KC_W-1:0];
          btkh_pkg::CFG_SELECT_MAX: select_max_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    pos_q      <= pos_d;
    best_val_q <= best_val_d;
    best_idx_q <= best_idx_d;
    res_word_q <= res_word_d;
  end

  // storage array: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (ren_a) begin
      rd_a_q <= mem_q[raddr_a];
    end
    if (ren_b) begin
      rd_b_q <= mem_q[raddr_b];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_word_o  = res_word_q;

endmodule

/* src/btkh_cmp.sv */
// ----------------------------------------------------------------------------
// btkh_cmp: shared ordering unit
// Tells whether value a belongs above value b in the active heap order.
// ----------------------------------------------------------------------------
module btkh_cmp (
  input  logic signed [btkh_pkg::VAL_W-1:0] a_i,
  input  logic signed [btkh_pkg::VAL_W-1:0] b_i,
  input  logic                              select_max_i,
  input  logic                              best_first_i,
  output logic                              before_o
);

  logic a_better;
  logic b_better;

  // strict "better" in both directions
  assign a_better = select_max_i ? (a_i > b_i) : (a_i < b_i);
  assign b_better = select_max_i ? (b_i > a_i) : (b_i < a_i);

  // best_first: root holds the best value, otherwise the worst
  assign before_o = best_first_i ? a_better : b_better;

endmodule
